/* design/fa_pkg.sv */
`timescale 1ns / 1ps
package fa_pkg;

  localparam int IN_W   = 16;
  localparam int MAG_W  = IN_W + 1;
  localparam int PROD_W = 31;          // 17x17 magnitude products stay below 2^31
  localparam int NUM_W  = PROD_W + 16;
  localparam int RW     = 48;          // divisor / remainder width
  localparam int FRAC   = 13;          // angle fraction bits, one division step per bit
  localparam int ANG_W  = 16;
  localparam int KW     = 15;

  localparam logic [KW-1:0]    K028    = 15'd18350;  // 0.28 in Q0.16
  localparam logic [ANG_W:0]   PI_FX   = 17'd25736;
  localparam logic [ANG_W:0]   HPI_FX  = 17'd12868;

  typedef struct packed {
    logic yneg;
    logic xneg;
    logic zneg;
    logic lo;      // |y| < |x|
    logic xzero;
    logic yzero;
  } side_t;

endpackage

/* design/fa_div_cell.sv */
`timescale 1ns / 1ps
module fa_div_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [fa_pkg::RW-1:0]  rem_i,
  input  logic [fa_pkg::RW-1:0]  den_i,
  input  logic [fa_pkg::FRAC-1:0] quo_i,
  input  fa_pkg::side_t          side_i,
  output logic                   valid_o,
  output logic [fa_pkg::RW-1:0]  rem_o,
  output logic [fa_pkg::RW-1:0]  den_o,
  output logic [fa_pkg::FRAC-1:0] quo_o,
  output fa_pkg::side_t          side_o
);

  logic [fa_pkg::RW:0]     sh;
  logic                    ge;
  logic [fa_pkg::RW:0]     diff;
  logic                    valid_q;
  logic [fa_pkg::RW-1:0]   rem_q, den_q;
  logic [fa_pkg::FRAC-1:0] quo_q;
  fa_pkg::side_t           side_q;

  // one restoring step
  assign sh   = {rem_i, 1'b0};
  assign ge   = sh >= {1'b0, den_i};
  assign diff = sh - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= ge ? diff[fa_pkg::RW-1:0] : sh[fa_pkg::RW-1:0];
      den_q  <= den_i;
      quo_q  <= {quo_i[fa_pkg::FRAC-2:0], ge};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

/* design/fa_front.sv */
`timescale 1ns / 1ps
module fa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [fa_pkg::IN_W-1:0] y_i,
  input  logic signed [fa_pkg::IN_W-1:0] x_i,
  output logic                          valid_o,
  output logic [fa_pkg::RW-1:0]         num_o,
  output logic [fa_pkg::RW-1:0]         den_o,
  output fa_pkg::side_t                 side_o
);

  logic [fa_pkg::MAG_W-1:0] ay_d, ax_d, ay_q, ax_q;
  logic                     yneg_d, xneg_d;
  fa_pkg::side_t            s1_d, s1_q, s2_q, s3_q, s4_q;
  logic [3:0]               v_q;
  logic [2*fa_pkg::MAG_W-1:0] pxx, pyy, pxy;
  logic [fa_pkg::PROD_W-1:0]  pa_q, pb_q, pn_q;
  logic [fa_pkg::NUM_W-1:0]   big_q, num3_q;
  logic [fa_pkg::KW+fa_pkg::PROD_W-1:0] kp_q;
  logic [fa_pkg::RW-1:0]      num4_q, den4_q;

  assign yneg_d = y_i[fa_pkg::IN_W-1];
  assign xneg_d = x_i[fa_pkg::IN_W-1];
  assign ay_d   = yneg_d ? fa_pkg::MAG_W'(-{y_i[fa_pkg::IN_W-1], y_i}) : {1'b0, y_i};
  assign ax_d   = xneg_d ? fa_pkg::MAG_W'(-{x_i[fa_pkg::IN_W-1], x_i}) : {1'b0, x_i};

  always_comb begin
    s1_d.yneg  = yneg_d;
    s1_d.xneg  = xneg_d;
    s1_d.zneg  = (yneg_d != xneg_d) && (ay_d != '0);
    s1_d.lo    = ay_d < ax_d;
    s1_d.xzero = ax_d == '0;
    s1_d.yzero = ay_d == '0;
  end

  assign pxx = ax_q * ax_q;
  assign pyy = ay_q * ay_q;
  assign pxy = ax_q * ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // magnitudes
      ay_q <= ay_d;
      ax_q <= ax_d;
      s1_q <= s1_d;
      // products, leading term first
      pa_q <= s1_q.lo ? pxx[fa_pkg::PROD_W-1:0] : pyy[fa_pkg::PROD_W-1:0];
      pb_q <= s1_q.lo ? pyy[fa_pkg::PROD_W-1:0] : pxx[fa_pkg::PROD_W-1:0];
      pn_q <= pxy[fa_pkg::PROD_W-1:0];
      s2_q <= s1_q;
      // scale by 0.28
      big_q  <= {pa_q, 16'd0};
      kp_q   <= fa_pkg::K028 * pb_q;
      num3_q <= {pn_q, 16'd0};
      s3_q   <= s2_q;
      // divisor sum
      den4_q <= fa_pkg::RW'(big_q) + fa_pkg::RW'(kp_q);
      num4_q <= fa_pkg::RW'(num3_q);
      s4_q   <= s3_q;
    end
  end

  assign valid_o = v_q[3];
  assign num_o   = num4_q;
  assign den_o   = den4_q;
  assign side_o  = s4_q;

endmodule

/* design/fast_atan2_approx.sv */
`timescale 1ns / 1ps
// fast_atan2_approx: four-quadrant atan2(y, x) approximation.
// Input channel: in_valid_i / in_ready_o carry one request of signed
// y_value_i, x_value_i (16 bit). Output channel: out_valid_o / out_ready_i
// carry angle_o, signed Q3.13 radians (pi = 25736).
// Pipeline from accepted request to out_valid_o:
// 4 front stages (magnitude, squares, 0.28 scaling, divisor sum),
// 13 division cells (one quotient bit each), 1 output fix-up register.
// Throughput: one request per clock while the output is not stalled. The chain of
// division cells sets it: each cell holds one request and hands it on every cycle the pipe advances.
// Stall: when a result is waiting and out_ready_i is low, the whole pipe
// holds; in_ready_o drops. Otherwise requests keep flowing while earlier
// ones are in flight.
// Reset: rst_ni (async, active low) clears all valid flags; no result is
// presented after reset until a new request has passed the pipe.
module fast_atan2_approx (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [fa_pkg::IN_W-1:0] y_value_i,
  input  logic signed [fa_pkg::IN_W-1:0] x_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [fa_pkg::ANG_W-1:0] angle_o
);

  logic en;
  logic out_valid_q;
  logic [fa_pkg::ANG_W-1:0] angle_q;

  logic                    v_w [0:fa_pkg::FRAC];
  logic [fa_pkg::RW-1:0]   r_w [0:fa_pkg::FRAC];
  logic [fa_pkg::RW-1:0]   d_w [0:fa_pkg::FRAC];
  logic [fa_pkg::FRAC-1:0] q_w [0:fa_pkg::FRAC];
  fa_pkg::side_t           s_w [0:fa_pkg::FRAC];

  // global advance: pipe moves unless a finished result is held
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  fa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .y_i     (y_value_i),
    .x_i     (x_value_i),
    .valid_o (v_w[0]),
    .num_o   (r_w[0]),
    .den_o   (d_w[0]),
    .side_o  (s_w[0])
  );
  assign q_w[0] = '0;

  for (genvar i = 0; i < fa_pkg::FRAC; i++) begin : g_cell
    fa_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_w[i]),
      .rem_i   (r_w[i]),
      .den_i   (d_w[i]),
      .quo_i   (q_w[i]),
      .side_i  (s_w[i]),
      .valid_o (v_w[i+1]),
      .rem_o   (r_w[i+1]),
      .den_o   (d_w[i+1]),
      .quo_o   (q_w[i+1]),
      .side_o  (s_w[i+1])
    );
  end

  // quadrant fix-up on the final quotient
  fa_pkg::side_t            sf;
  logic [fa_pkg::ANG_W:0]   qx, sq, res;
  assign sf = s_w[fa_pkg::FRAC];
  assign qx = {{(fa_pkg::ANG_W+1-fa_pkg::FRAC){1'b0}}, q_w[fa_pkg::FRAC]};
  assign sq = sf.zneg ? -qx : qx;

  always_comb begin
    if (sf.xzero) begin
      if (sf.yzero) res = '0;
      else          res = sf.yneg ? -fa_pkg::HPI_FX : fa_pkg::HPI_FX;
    end else if (sf.lo) begin
      res = sq;
      if (sf.xneg) res = sf.yneg ? sq - fa_pkg::PI_FX : sq + fa_pkg::PI_FX;
    end else begin
      res = fa_pkg::HPI_FX - sq;
      if (sf.yneg) res = fa_pkg::HPI_FX - sq - fa_pkg::PI_FX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_w[fa_pkg::FRAC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= res[fa_pkg::ANG_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign angle_o     = angle_q;

  // result always inside [-pi, pi]
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_o <= 16'sd25736 && angle_o >= -16'sd25736))
    else $error("angle out of range");

  // a held result freezes the divider chain
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(r_w[1]) && $stable(q_w[fa_pkg::FRAC])))
    else $error("pipe moved during stall");

endmodule
